// ===== sv/csvfp_pkg.sv =====
// Shared types and constants for the CSV field parser.
`timescale 1ns / 1ps

package csvfp_pkg;

   typedef enum logic [1:0] {
      MODE_PLAIN      = 2'd0,
      MODE_QUOTED     = 2'd1,
      MODE_QUOTE_SEEN = 2'd2,
      MODE_DISCARD    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_BYTE        = 3'd0,
      KIND_FIELD_END   = 3'd1,
      KIND_ROW_END     = 3'd2,
      KIND_ERROR       = 3'd3,
      KIND_DISCARD_END = 3'd4
   } kind_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [7:0] DELIM_RESET = 8'd44;
   localparam logic [7:0] COLUMN_MAX  = 8'd255;

   function automatic logic is_terminator(input logic [7:0] c);
      return (c == CH_LF) || (c == CH_CR) || (c == CH_NUL);
   endfunction

endpackage

// ===== sv/csv_field_parser_unit.sv =====
// Top level of the CSV field parser: byte-wise mode machine with a result register.
`timescale 1ns / 1ps

// One byte is taken per clock when the result side keeps up. Each accepted byte
// passes through the mode logic in the cycle it is accepted and its result, if
// any, appears on rsp_* at the next cycle; the result register is the only
// stage, and throughput is one byte per cycle. The input is stalled only while
// a result is held and rsp_stall is high. Bytes that give no result (opening
// or closing quotes, bytes dropped after a format error) leave rsp_valid low.
// The delimiter register resets to a comma and may be rewritten through
// csr_wr_en/csr_wr_data while the block is idle.
module csv_field_parser_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_kind,
   output logic [7:0]            rsp_out_byte,
   output logic [7:0]            rsp_column
);

   logic [7:0]          delim_ff;
   csvfp_pkg::mode_type mode_ff, mode_in;
   logic [7:0]          col_ff, col_in;
   logic                valid_ff, valid_in;
   csvfp_pkg::kind_type kind_ff, kind_in;
   logic [7:0]          byte_ff, byte_in;
   logic [7:0]          rcol_ff;
   logic                accept;
   logic                res_valid;
   csvfp_pkg::kind_type res_kind;
   logic [7:0]          res_byte;
   logic [7:0]          col_inc;

   assign req_stall = valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign col_inc   = (col_ff == csvfp_pkg::COLUMN_MAX) ? col_ff : col_ff + 8'd1;

   // Mode transition and result for the incoming byte.
   always_comb begin
      logic term;
      logic is_delim;
      logic is_quote;
      term      = csvfp_pkg::is_terminator(req_in_byte);
      is_delim  = (req_in_byte == delim_ff);
      is_quote  = (req_in_byte == csvfp_pkg::CH_QUOTE);
      mode_in   = mode_ff;
      col_in    = col_ff;
      res_valid = 1'b0;
      res_kind  = csvfp_pkg::KIND_BYTE;
      res_byte  = 8'd0;
      unique case (mode_ff)
         csvfp_pkg::MODE_PLAIN: begin
            if (term) begin
               res_valid = 1'b1;
               res_kind  = csvfp_pkg::KIND_ROW_END;
               col_in    = 8'd0;
            end else if (is_delim) begin
               res_valid = 1'b1;
               res_kind  = csvfp_pkg::KIND_FIELD_END;
               col_in    = col_inc;
            end else if (is_quote) begin
               mode_in = csvfp_pkg::MODE_QUOTED;
            end else begin
               res_valid = 1'b1;
               res_byte  = req_in_byte;
            end
         end
         csvfp_pkg::MODE_QUOTED: begin
            if (is_quote) begin
               mode_in = csvfp_pkg::MODE_QUOTE_SEEN;
            end else begin
               res_valid = 1'b1;
               res_byte  = req_in_byte;
            end
         end
         csvfp_pkg::MODE_QUOTE_SEEN: begin
            if (is_quote) begin
               mode_in   = csvfp_pkg::MODE_QUOTED;
               res_valid = 1'b1;
               res_byte  = csvfp_pkg::CH_QUOTE;
            end else if (is_delim) begin
               mode_in   = csvfp_pkg::MODE_PLAIN;
               res_valid = 1'b1;
               res_kind  = csvfp_pkg::KIND_FIELD_END;
               col_in    = col_inc;
            end else if (term) begin
               mode_in   = csvfp_pkg::MODE_PLAIN;
               res_valid = 1'b1;
               res_kind  = csvfp_pkg::KIND_ROW_END;
               col_in    = 8'd0;
            end else begin
               mode_in   = csvfp_pkg::MODE_DISCARD;
               res_valid = 1'b1;
               res_kind  = csvfp_pkg::KIND_ERROR;
            end
         end
         csvfp_pkg::MODE_DISCARD: begin
            // drop everything up to the next terminator
            if (term) begin
               mode_in   = csvfp_pkg::MODE_PLAIN;
               res_valid = 1'b1;
               res_kind  = csvfp_pkg::KIND_DISCARD_END;
               col_in    = 8'd0;
            end
         end
         default: begin
            mode_in = csvfp_pkg::MODE_PLAIN;
         end
      endcase
   end

   // Result register: load on accept, clear once taken.
   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = res_valid;
         kind_in  = res_kind;
         byte_in  = res_byte;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= csvfp_pkg::DELIM_RESET;
         mode_ff  <= csvfp_pkg::MODE_PLAIN;
         col_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            delim_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff <= mode_in;
            col_ff  <= col_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      if (accept) begin
         rcol_ff <= col_ff;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_column   = rcol_ff;

endmodule

// ===== sv/csvfp_checker.sv =====
// Port-level checker for the CSV field parser and its bind.
`timescale 1ns / 1ps

module csvfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [7:0] rsp_column
);

   logic row_end;
   logic field_end;
   logic taken;

   assign taken     = rsp_valid & ~rsp_stall;
   assign row_end   = (rsp_kind == csvfp_pkg::KIND_ROW_END) ||
                      (rsp_kind == csvfp_pkg::KIND_DISCARD_END);
   assign field_end = (rsp_kind == csvfp_pkg::KIND_FIELD_END);

   // hold a stalled transaction
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_column))
      else $error("stalled result changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == csvfp_pkg::KIND_BYTE) || field_end || row_end ||
      (rsp_kind == csvfp_pkg::KIND_ERROR))
      else $error("result kind out of range");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != csvfp_pkg::KIND_BYTE) |-> rsp_out_byte == 8'd0)
      else $error("non-data result carries a byte");

   // a result right after a row end starts the next row at column zero
   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      taken && row_end |=> !rsp_valid || rsp_column == 8'd0)
      else $error("column not cleared after row end");

   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      taken && field_end && rsp_column != csvfp_pkg::COLUMN_MAX |=>
      !rsp_valid || rsp_column == $past(rsp_column) + 8'd1)
      else $error("column did not advance after field end");

endmodule

bind csv_field_parser_unit csvfp_checker u_csvfp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_kind     (rsp_kind),
   .rsp_out_byte (rsp_out_byte),
   .rsp_column   (rsp_column)
);

// ===== dv/tb_top.sv =====
// Testbench for the CSV field parser: directed and random byte streams checked per result.
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [7:0] column;
   } parse_result_type;

   localparam int WATCHDOG_LIMIT = 2000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic [7:0] rsp_column;

   // parser state as the testbench sees it
   csvfp_pkg::mode_type mode_model   = csvfp_pkg::MODE_PLAIN;
   logic [7:0]          column_model = 8'd0;
   logic [7:0]          delim_model  = csvfp_pkg::DELIM_RESET;
   parse_result_type    pending_results [$];

   logic [7:0] cur_delim     = csvfp_pkg::DELIM_RESET;
   int         send_idle_pct = 0;
   int         stall_pct     = 0;
   int         quiet_cycles  = 0;
   int         bytes_sent    = 0;
   int         results_seen  = 0;
   int         delim_writes  = 0;
   int         error_count   = 0;

   csv_field_parser_unit uut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_column   (rsp_column)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic bit ends_row(input logic [7:0] c);
      return (c == csvfp_pkg::CH_LF) || (c == csvfp_pkg::CH_CR) ||
             (c == csvfp_pkg::CH_NUL);
   endfunction

   // column is taken before the byte's effect on the count
   task automatic push_result(input logic [2:0] kind, input logic [7:0] data);
      parse_result_type r;
      r.kind   = kind;
      r.data   = data;
      r.column = column_model;
      pending_results.insert(pending_results.size(), r);
   endtask

   task automatic close_field();
      push_result(csvfp_pkg::KIND_FIELD_END, 8'd0);
      if (column_model != csvfp_pkg::COLUMN_MAX) column_model = column_model + 8'd1;
      mode_model = csvfp_pkg::MODE_PLAIN;
   endtask

   task automatic close_row(input logic [2:0] kind);
      push_result(kind, 8'd0);
      column_model = 8'd0;
      mode_model   = csvfp_pkg::MODE_PLAIN;
   endtask

   task automatic predict_byte(input logic [7:0] c);
      case (mode_model)
         csvfp_pkg::MODE_PLAIN: begin
            if (ends_row(c)) close_row(csvfp_pkg::KIND_ROW_END);
            else if (c == delim_model) close_field();
            else if (c == csvfp_pkg::CH_QUOTE) mode_model = csvfp_pkg::MODE_QUOTED;
            else push_result(csvfp_pkg::KIND_BYTE, c);
         end
         csvfp_pkg::MODE_QUOTED: begin
            if (c == csvfp_pkg::CH_QUOTE) mode_model = csvfp_pkg::MODE_QUOTE_SEEN;
            else push_result(csvfp_pkg::KIND_BYTE, c);
         end
         csvfp_pkg::MODE_QUOTE_SEEN: begin
            if (c == csvfp_pkg::CH_QUOTE) begin
               mode_model = csvfp_pkg::MODE_QUOTED;
               push_result(csvfp_pkg::KIND_BYTE, csvfp_pkg::CH_QUOTE);
            end else if (c == delim_model) begin
               close_field();
            end else if (ends_row(c)) begin
               close_row(csvfp_pkg::KIND_ROW_END);
            end else begin
               mode_model = csvfp_pkg::MODE_DISCARD;
               push_result(csvfp_pkg::KIND_ERROR, 8'd0);
            end
         end
         default: begin
            if (ends_row(c)) close_row(csvfp_pkg::KIND_DISCARD_END);
         end
      endcase
   endtask

   always @(posedge clock) begin : result_monitor
      parse_result_type want;
      bit               moved;
      moved = 1'b0;
      if (reset) begin
         mode_model   = csvfp_pkg::MODE_PLAIN;
         column_model = 8'd0;
         delim_model  = csvfp_pkg::DELIM_RESET;
         pending_results.delete();
      end else begin
         if (csr_wr_en) delim_model = csr_wr_data;
         if (req_valid && !req_stall) begin
            predict_byte(req_in_byte);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transaction kind %0d byte %02h column %0d",
                        $time, rsp_kind, rsp_out_byte, rsp_column);
            end else begin
               want = pending_results.pop_front();
               results_seen++;
               if (rsp_kind !== want.kind) begin
                  error_count++;
                  $display("%0t: kind expected %0d, got %0d", $time, want.kind, rsp_kind);
               end
               if (rsp_out_byte !== want.data) begin
                  error_count++;
                  $display("%0t: out_byte expected %02h, got %02h",
                           $time, want.data, rsp_out_byte);
               end
               if (rsp_column !== want.column) begin
                  error_count++;
                  $display("%0t: column expected %0d, got %0d",
                           $time, want.column, rsp_column);
               end
            end
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // hold the sender until every expected transaction is out
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_delimiter(input logic [7:0] d);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      cur_delim = d;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      delim_writes++;
   endtask

   function automatic logic [7:0] any_terminator();
      case ($urandom_range(2))
         0:       return csvfp_pkg::CH_LF;
         1:       return csvfp_pkg::CH_CR;
         default: return csvfp_pkg::CH_NUL;
      endcase
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (ends_row(c) || c == cur_delim || c == csvfp_pkg::CH_QUOTE);
      return c;
   endfunction

   // inside quotes: mostly any byte but a quote, at times a delimiter or a terminator
   function automatic logic [7:0] quoted_char();
      logic [7:0] c;
      case ($urandom_range(9))
         0:       c = cur_delim;
         1:       c = any_terminator();
         default: do c = 8'($urandom_range(255)); while (c == csvfp_pkg::CH_QUOTE);
      endcase
      return c;
   endfunction

   task automatic send_row();
      int style;
      int fields;
      int len;
      style = $urandom_range(99);
      if (style < 10) begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
         return;
      end
      fields = $urandom_range(1, 6);
      for (int f = 0; f < fields; f++) begin
         if (f != 0) send_byte(cur_delim);
         len = $urandom_range(0, 4);
         if ($urandom_range(2) == 0) begin
            send_byte(csvfp_pkg::CH_QUOTE);
            repeat (len) begin
               if ($urandom_range(5) == 0) begin
                  send_byte(csvfp_pkg::CH_QUOTE);
                  send_byte(csvfp_pkg::CH_QUOTE);
               end else begin
                  send_byte(quoted_char());
               end
            end
            send_byte(csvfp_pkg::CH_QUOTE);
            // junk after the closing quote forces a format error
            if (style < 20) begin
               send_byte(plain_char());
               repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
            end
         end else begin
            repeat (len) send_byte(plain_char());
         end
      end
      send_byte(any_terminator());
   endtask

   task automatic test_directed_cases();
      logic [7:0] seq [$];
      send_idle_pct = 0;
      stall_pct     = 0;
      seq = '{8'h41, 8'hFF, csvfp_pkg::DELIM_RESET,
              csvfp_pkg::CH_QUOTE, csvfp_pkg::DELIM_RESET, csvfp_pkg::CH_QUOTE,
              csvfp_pkg::CH_QUOTE, csvfp_pkg::CH_QUOTE, csvfp_pkg::DELIM_RESET,
              csvfp_pkg::CH_QUOTE, 8'h78, csvfp_pkg::CH_QUOTE, csvfp_pkg::CH_CR,
              8'h62, csvfp_pkg::CH_QUOTE, csvfp_pkg::DELIM_RESET, csvfp_pkg::CH_QUOTE,
              csvfp_pkg::CH_LF,
              csvfp_pkg::CH_QUOTE, 8'h71, csvfp_pkg::CH_QUOTE, 8'h7A, 8'h6B,
              csvfp_pkg::DELIM_RESET, csvfp_pkg::CH_LF,
              csvfp_pkg::CH_NUL};
      foreach (seq[i]) send_byte(seq[i]);
      wait_idle();
   endtask

   // one row with more fields than the column count can hold
   task automatic test_column_saturation();
      send_idle_pct = 38;
      stall_pct     = 38;
      for (int f = 0; f < 258; f++) begin
         if ($urandom_range(1)) send_byte(plain_char());
         send_byte(cur_delim);
      end
      send_byte(plain_char());
      send_byte(csvfp_pkg::CH_LF);
      wait_idle();
   endtask

   task automatic test_random_rows(input int send_pct, input int recv_pct,
                                   input logic [7:0] first_delim,
                                   input logic [7:0] second_delim, input int count);
      int target;
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      set_delimiter(first_delim);
      target = bytes_sent + count / 4;
      while (bytes_sent < target) send_row();
      wait_idle();
      target = bytes_sent + count / 4;
      while (bytes_sent < target) send_row();
      set_delimiter(second_delim);
      target = bytes_sent + count / 2;
      while (bytes_sent < target) send_row();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_column_saturation();
      test_random_rows(0, 0, csvfp_pkg::DELIM_RESET, csvfp_pkg::CH_NUL, 240);
      test_random_rows(76, 0, 8'hFF, csvfp_pkg::CH_QUOTE, 240);
      test_random_rows(0, 76, csvfp_pkg::CH_LF, 8'h3B, 240);
      test_random_rows(38, 38, 8'h09, 8'($urandom_range(255)), 240);
      wait_idle();
      repeat (4) @(posedge clock);
      $display("Sent %0d bytes over %0d delimiter writes, checked %0d results,",
               bytes_sent, delim_writes, results_seen);
      $display("with quoted fields, format errors, a saturated column and four idle mixes.");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
